// ===== hdl/rdcw_pkg.sv =====
// ----------------------------------------------------------------------------
// rdcw_pkg
// shared types and codes for the range distinct-count window unit
// ----------------------------------------------------------------------------
package rdcw_pkg;

    localparam int FIELD_W = 10;
    localparam int COUNT_W = 11;
    localparam int TAG_W   = 16;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] element_value;
        logic [FIELD_W-1:0] left_end;
        logic [FIELD_W-1:0] right_end;
        logic [TAG_W-1:0]   query_tag;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] distinct_count;
        logic [TAG_W-1:0]   answer_tag;
        logic               status;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_CLEAR,
        OP_REFUSE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] element_value;
        logic [FIELD_W-1:0] left_end;
        logic [FIELD_W-1:0] right_end;
        logic [TAG_W-1:0]   tag;
    } t_job;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PLAN,
        ST_ARRAY,
        ST_COUNT,
        ST_REPLY
    } t_back_state;

    typedef enum logic [1:0] {
        STEP_ADD_LEFT,
        STEP_ADD_RIGHT,
        STEP_DROP_LEFT,
        STEP_DROP_RIGHT
    } t_step;

endpackage

// ===== hdl/range_distinct_count_window_unit.sv =====
// ----------------------------------------------------------------------------
// range_distinct_count_window_unit
// distinct-value count over a movable window of a loadable array
// ----------------------------------------------------------------------------
// channel  direction  handshake      payload
// in       input      valid / stall  rdcw_pkg::t_in_item
// out      output     valid / stall  rdcw_pkg::t_out_item
// cfg      input      valid / ready  used_length, 11 bits
//
// load and refused requests go straight from idle to reply in the back section
// a query adds or removes window elements one by one, a clear drops every element
// each element step is an array read, a count read and a count write
// after reset a sweep zeroes all VALUE_COUNT counts, input stalled
// a two-entry queue and the output register let requests arrive while the back works
// ----------------------------------------------------------------------------
module range_distinct_count_window_unit #(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_COUNT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  rdcw_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output rdcw_pkg::t_out_item          o_out_item,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rdcw_pkg::COUNT_W-1:0] i_cfg_data
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_nonempty;
    logic           w_busy;
    rdcw_pkg::t_job w_push_job;
    rdcw_pkg::t_job w_head_job;

    rdcw_front #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_COUNT (VALUE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (w_full),
        .i_busy       (w_busy),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    rdcw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_push_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_job      (w_head_job)
    );

    rdcw_back #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_COUNT (VALUE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nonempty  (w_nonempty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hdl/rdcw_ram.sv =====
// ----------------------------------------------------------------------------
// rdcw_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rdcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/rdcw_queue.sv =====
// ----------------------------------------------------------------------------
// rdcw_queue
// two-entry job queue between the front and back sections
// ----------------------------------------------------------------------------
module rdcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rdcw_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output rdcw_pkg::t_job o_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    rdcw_pkg::t_job   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_fill;
    logic [PTR_W:0]   n_fill;

    assign o_full     = (r_fill == (PTR_W+1)'(DEPTH));
    assign o_nonempty = (r_fill != '0);
    assign o_job      = r_slot[r_rd_ptr];
    assign n_fill     = r_fill + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_fill <= n_fill;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== hdl/rdcw_front.sv =====
// ----------------------------------------------------------------------------
// rdcw_front
// request intake, length register and command classification
// ----------------------------------------------------------------------------
module rdcw_front #(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_COUNT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  rdcw_pkg::t_in_item             i_in_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rdcw_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic                           i_queue_full,
    input  logic                           i_busy,
    output logic                           o_push,
    output rdcw_pkg::t_job                 o_job
);

    localparam logic [rdcw_pkg::COUNT_W-1:0] LENGTH_RESET = 11'd1024;

    logic [rdcw_pkg::COUNT_W-1:0] r_used_length;
    logic                         w_load_ok;
    logic                         w_query_ok;
    rdcw_pkg::t_op                w_op;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_queue_full || i_busy;
    assign o_push      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_length <= LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_used_length <= i_cfg_data;
        end
    end

    assign w_load_ok = (32'(i_in_item.position) < ARRAY_DEPTH)
                    && (32'(i_in_item.element_value) < VALUE_COUNT);

    assign w_query_ok = ({1'b0, i_in_item.left_end} <= ({1'b0, i_in_item.right_end} + 11'd1))
                     && ({1'b0, i_in_item.right_end} < r_used_length)
                     && (32'(i_in_item.right_end) < ARRAY_DEPTH);

    always_comb begin
        unique case (i_in_item.command)
            rdcw_pkg::CMD_LOAD:  w_op = w_load_ok ? rdcw_pkg::OP_LOAD : rdcw_pkg::OP_REFUSE;
            rdcw_pkg::CMD_QUERY: w_op = w_query_ok ? rdcw_pkg::OP_QUERY : rdcw_pkg::OP_REFUSE;
            rdcw_pkg::CMD_CLEAR: w_op = rdcw_pkg::OP_CLEAR;
            default:             w_op = rdcw_pkg::OP_REFUSE;
        endcase
    end

    always_comb begin
        o_job.op            = w_op;
        o_job.position      = i_in_item.position;
        o_job.element_value = i_in_item.element_value;
        o_job.left_end      = i_in_item.left_end;
        o_job.right_end     = i_in_item.right_end;
        o_job.tag           = i_in_item.query_tag;
    end

endmodule

// ===== hdl/rdcw_back.sv =====
// ----------------------------------------------------------------------------
// rdcw_back
// window walker: array store, occurrence counts and result register
// ----------------------------------------------------------------------------
module rdcw_back #(
    parameter int ARRAY_DEPTH = 1024,
    parameter int VALUE_COUNT = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_nonempty,
    input  rdcw_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_busy,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rdcw_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(ARRAY_DEPTH);
    localparam int VW = $clog2(VALUE_COUNT);
    localparam int CW = rdcw_pkg::COUNT_W;

    rdcw_pkg::t_back_state r_state;
    rdcw_pkg::t_back_state n_state;
    rdcw_pkg::t_job        r_job;
    rdcw_pkg::t_step       r_step;
    rdcw_pkg::t_out_item   r_out;
    logic [CW-1:0]         r_left;
    logic [CW-1:0]         r_end;
    logic [CW-1:0]         r_distinct;
    logic [CW-1:0]         r_count;
    logic                  r_status;
    logic [VW-1:0]         r_value;
    logic [VW-1:0]         r_sweep;
    logic                  r_out_valid;

    logic [CW-1:0]         w_ql;
    logic [CW-1:0]         w_qe;
    logic                  w_empty;
    logic                  w_found;
    rdcw_pkg::t_step       w_step;
    logic [CW-1:0]         w_step_pos;
    logic                  w_slot_free;
    logic                  w_take;
    logic [CW-1:0]         w_new_cnt;
    logic [CW-1:0]         w_new_distinct;

    logic                  w_arr_wr_en;
    logic [AW-1:0]         w_arr_wr_addr;
    logic [VW-1:0]         w_arr_wr_data;
    logic                  w_arr_rd_en;
    logic [AW-1:0]         w_arr_rd_addr;
    logic [VW-1:0]         w_arr_rd_data;
    logic                  w_cnt_wr_en;
    logic [VW-1:0]         w_cnt_wr_addr;
    logic [CW-1:0]         w_cnt_wr_data;
    logic                  w_cnt_rd_en;
    logic [VW-1:0]         w_cnt_rd_addr;
    logic [CW-1:0]         w_cnt_rd_data;

    rdcw_ram #(
        .WIDTH (VW),
        .DEPTH (ARRAY_DEPTH)
    ) u_array (
        .i_clk     (i_clk),
        .i_wr_en   (w_arr_wr_en),
        .i_wr_addr (w_arr_wr_addr),
        .i_wr_data (w_arr_wr_data),
        .i_rd_en   (w_arr_rd_en),
        .i_rd_addr (w_arr_rd_addr),
        .o_rd_data (w_arr_rd_data)
    );

    rdcw_ram #(
        .WIDTH (CW),
        .DEPTH (VALUE_COUNT)
    ) u_counts (
        .i_clk     (i_clk),
        .i_wr_en   (w_cnt_wr_en),
        .i_wr_addr (w_cnt_wr_addr),
        .i_wr_data (w_cnt_wr_data),
        .i_rd_en   (w_cnt_rd_en),
        .i_rd_addr (w_cnt_rd_addr),
        .o_rd_data (w_cnt_rd_data)
    );

    assign w_ql        = {1'b0, r_job.left_end};
    assign w_qe        = {1'b0, r_job.right_end} + CW'(1);
    assign w_empty     = (r_end <= r_left);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // next window step, widening before shrinking; a clear only drops from the left
    always_comb begin
        w_found    = 1'b0;
        w_step     = rdcw_pkg::STEP_DROP_LEFT;
        w_step_pos = r_left;
        if (r_job.op == rdcw_pkg::OP_CLEAR) begin
            w_found = (r_left < r_end);
        end else if (r_left > w_ql) begin
            w_found    = 1'b1;
            w_step     = rdcw_pkg::STEP_ADD_LEFT;
            w_step_pos = r_left - CW'(1);
        end else if (r_end < w_qe) begin
            w_found    = 1'b1;
            w_step     = rdcw_pkg::STEP_ADD_RIGHT;
            w_step_pos = r_end;
        end else if (r_left < w_ql) begin
            w_found    = 1'b1;
            w_step     = rdcw_pkg::STEP_DROP_LEFT;
            w_step_pos = r_left;
        end else if (r_end > w_qe) begin
            w_found    = 1'b1;
            w_step     = rdcw_pkg::STEP_DROP_RIGHT;
            w_step_pos = r_end - CW'(1);
        end
    end

    // occurrence count update
    always_comb begin
        w_take = (r_step == rdcw_pkg::STEP_ADD_LEFT) || (r_step == rdcw_pkg::STEP_ADD_RIGHT);
        w_new_cnt      = w_cnt_rd_data;
        w_new_distinct = r_distinct;
        if (w_take) begin
            w_new_cnt = w_cnt_rd_data + CW'(1);
            if (w_cnt_rd_data == '0) begin
                w_new_distinct = r_distinct + CW'(1);
            end
        end else if (w_cnt_rd_data != '0) begin
            w_new_cnt = w_cnt_rd_data - CW'(1);
            if (w_cnt_rd_data == CW'(1) && r_distinct != '0) begin
                w_new_distinct = r_distinct - CW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rdcw_pkg::ST_INIT: begin
                if (r_sweep == VW'(VALUE_COUNT - 1)) begin
                    n_state = rdcw_pkg::ST_IDLE;
                end
            end
            rdcw_pkg::ST_IDLE: begin
                if (i_nonempty) begin
                    unique case (i_job.op) inside
                        rdcw_pkg::OP_QUERY, rdcw_pkg::OP_CLEAR: n_state = rdcw_pkg::ST_PLAN;
                        default:                                n_state = rdcw_pkg::ST_REPLY;
                    endcase
                end
            end
            rdcw_pkg::ST_PLAN: begin
                n_state = w_found ? rdcw_pkg::ST_ARRAY : rdcw_pkg::ST_REPLY;
            end
            rdcw_pkg::ST_ARRAY: n_state = rdcw_pkg::ST_COUNT;
            rdcw_pkg::ST_COUNT: n_state = rdcw_pkg::ST_PLAN;
            rdcw_pkg::ST_REPLY: begin
                if (w_slot_free) begin
                    n_state = rdcw_pkg::ST_IDLE;
                end
            end
            default: n_state = rdcw_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_busy        = (r_state == rdcw_pkg::ST_INIT);
        o_pop         = (r_state == rdcw_pkg::ST_IDLE) && i_nonempty;
        w_arr_wr_en   = o_pop && (i_job.op == rdcw_pkg::OP_LOAD) && w_empty;
        w_arr_wr_addr = AW'(i_job.position);
        w_arr_wr_data = VW'(i_job.element_value);
        w_arr_rd_en   = (r_state == rdcw_pkg::ST_PLAN) && w_found;
        w_arr_rd_addr = AW'(w_step_pos);
        w_cnt_rd_en   = (r_state == rdcw_pkg::ST_ARRAY);
        w_cnt_rd_addr = w_arr_rd_data;
        w_cnt_wr_en   = (r_state == rdcw_pkg::ST_INIT) || (r_state == rdcw_pkg::ST_COUNT);
        w_cnt_wr_addr = (r_state == rdcw_pkg::ST_INIT) ? r_sweep : r_value;
        w_cnt_wr_data = (r_state == rdcw_pkg::ST_INIT) ? '0 : w_new_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rdcw_pkg::ST_INIT;
            r_sweep     <= '0;
            r_left      <= '0;
            r_end       <= '0;
            r_distinct  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rdcw_pkg::ST_INIT) begin
                r_sweep <= r_sweep + VW'(1);
            end
            if (r_state == rdcw_pkg::ST_PLAN && !w_found && r_job.op == rdcw_pkg::OP_CLEAR) begin
                r_left     <= '0;
                r_end      <= '0;
                r_distinct <= '0;
            end
            if (r_state == rdcw_pkg::ST_COUNT) begin
                r_distinct <= w_new_distinct;
                case (r_step)
                    rdcw_pkg::STEP_ADD_LEFT:  r_left <= r_left - CW'(1);
                    rdcw_pkg::STEP_ADD_RIGHT: r_end  <= r_end + CW'(1);
                    rdcw_pkg::STEP_DROP_LEFT: r_left <= r_left + CW'(1);
                    default:                  r_end  <= r_end - CW'(1);
                endcase
            end
            if (r_state == rdcw_pkg::ST_REPLY && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job    <= i_job;
            r_count  <= '0;
            r_status <= (i_job.op == rdcw_pkg::OP_LOAD && w_empty) ? rdcw_pkg::STATUS_OK
                                                                   : rdcw_pkg::STATUS_REFUSED;
        end
        if (r_state == rdcw_pkg::ST_PLAN) begin
            r_step <= w_step;
            if (!w_found) begin
                r_status <= rdcw_pkg::STATUS_OK;
                r_count  <= (r_job.op == rdcw_pkg::OP_CLEAR) ? '0 : r_distinct;
            end
        end
        if (r_state == rdcw_pkg::ST_ARRAY) begin
            r_value <= w_arr_rd_data;
        end
        if (r_state == rdcw_pkg::ST_REPLY && w_slot_free) begin
            r_out.distinct_count <= r_count;
            r_out.answer_tag     <= r_job.tag;
            r_out.status         <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/rdcw_checker.sv =====
// ----------------------------------------------------------------------------
// rdcw_checker
// port-level assertions for the range distinct-count window unit
// ----------------------------------------------------------------------------
module rdcw_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rdcw_pkg::t_out_item o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // refusals never carry a count
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == rdcw_pkg::STATUS_REFUSED)
        |-> (o_out_item.distinct_count == '0))
        else $error("refused request carries a nonzero count");

    // count sweep after reset holds off requests and results
    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> o_in_stall && !o_out_valid)
        else $error("request accepted or result shown during the count sweep");

endmodule

bind range_distinct_count_window_unit rdcw_checker u_checker (.*);

// ===== bench/range_distinct_count_window_unit_tb.sv =====
// ----------------------------------------------------------------------------
// range_distinct_count_window_unit_tb
// Drives load, query, clear and unknown requests into the window unit and
// checks each answer against its typed table row or a cycle-free model of the
// array, the per-value counts and the window. Directed table rows come first,
// then random sequences: a clear or empty query, a burst of loads, a walk of
// queries, with noise and length register changes between sequences.
// ----------------------------------------------------------------------------
module range_distinct_count_window_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 1024;
    localparam int VALUES         = 1024;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int WATCHDOG_LIMIT = 40000;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        bit                 do_cfg;
        int                 cfg_val;
        rdcw_pkg::t_in_item item;
        bit                 typed;
        logic               want_status;
    } t_dir_row;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_in_valid  = 1'b0;
    logic                         o_in_stall;
    rdcw_pkg::t_in_item           i_in_item   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    rdcw_pkg::t_out_item          o_out_item;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [rdcw_pkg::COUNT_W-1:0] i_cfg_data  = '0;

    logic [rdcw_pkg::FIELD_W-1:0] store_vals [DEPTH];
    bit                           store_written [DEPTH];
    int                           occ [VALUES];
    int                           win_l;
    int                           win_r;
    int                           distinct_now;
    int                           length_reg;
    int                           written_prefix;

    rdcw_pkg::t_out_item answers_due [$];
    rdcw_pkg::t_out_item oldest;
    t_dir_row            dir_rows [$];
    int                  mismatches = 0;
    int                  items_sent = 0;
    int                  quiet      = 0;
    bit                  calm       = 1'b0;

    range_distinct_count_window_unit #(
        .ARRAY_DEPTH(DEPTH),
        .VALUE_COUNT(VALUES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    function automatic logic [rdcw_pkg::FIELD_W-1:0] to_field(input int v);
        return v[rdcw_pkg::FIELD_W-1:0];
    endfunction

    task automatic reset_window_model();
        foreach (store_vals[p]) begin
            store_vals[p]    = '0;
            store_written[p] = 1'b0;
        end
        foreach (occ[v]) occ[v] = 0;
        win_l          = 0;
        win_r          = -1;
        distinct_now   = 0;
        length_reg     = 1024;
        written_prefix = 0;
    endtask

    function automatic void add_pos(input int p);
        int v;
        v = int'(store_vals[p]);
        occ[v]++;
        if (occ[v] == 1) distinct_now++;
    endfunction

    function automatic void drop_pos(input int p);
        int v;
        v = int'(store_vals[p]);
        if (occ[v] == 0) return;
        occ[v]--;
        if (occ[v] == 0 && distinct_now > 0) distinct_now--;
    endfunction

    function automatic int effective_length();
        return (length_reg > DEPTH) ? DEPTH : length_reg;
    endfunction

    task automatic step_window_model(input rdcw_pkg::t_in_item it,
                                     output rdcw_pkg::t_out_item ans);
        int ql;
        int qr;
        ql = int'(it.left_end);
        qr = int'(it.right_end);
        ans.distinct_count = '0;
        ans.answer_tag     = it.query_tag;
        ans.status         = rdcw_pkg::STATUS_REFUSED;
        case (it.command)
            rdcw_pkg::CMD_LOAD: begin
                if (win_r < win_l) begin
                    store_vals[it.position]    = it.element_value;
                    store_written[it.position] = 1'b1;
                    while (written_prefix < DEPTH && store_written[written_prefix])
                        written_prefix++;
                    ans.status = rdcw_pkg::STATUS_OK;
                end
            end
            rdcw_pkg::CMD_QUERY: begin
                if (ql <= qr + 1 && qr < effective_length()) begin
                    while (win_l > ql) begin
                        win_l--;
                        add_pos(win_l);
                    end
                    while (win_r < qr) begin
                        win_r++;
                        add_pos(win_r);
                    end
                    while (win_l < ql) begin
                        drop_pos(win_l);
                        win_l++;
                    end
                    while (win_r > qr) begin
                        drop_pos(win_r);
                        win_r--;
                    end
                    ans.distinct_count = distinct_now[rdcw_pkg::COUNT_W-1:0];
                    ans.status         = rdcw_pkg::STATUS_OK;
                end
            end
            rdcw_pkg::CMD_CLEAR: begin
                foreach (occ[v]) occ[v] = 0;
                distinct_now = 0;
                win_l        = 0;
                win_r        = -1;
                ans.status   = rdcw_pkg::STATUS_OK;
            end
            default: ;
        endcase
    endtask

    // right ends below this bound never reach an unloaded entry
    function automatic int visible_limit();
        int eff;
        eff = effective_length();
        return (eff < written_prefix) ? eff : written_prefix;
    endfunction

    function automatic bit query_is_safe(input int ql, input int qr);
        if (!(ql <= qr + 1 && qr < effective_length())) return 1'b1;
        return qr < written_prefix;
    endfunction

    function automatic rdcw_pkg::t_in_item rand_item(input logic [1:0] cmd);
        logic [63:0]        raw;
        rdcw_pkg::t_in_item it;
        raw        = {$urandom, $urandom};
        it         = raw[$bits(rdcw_pkg::t_in_item)-1:0];
        it.command = cmd;
        return it;
    endfunction

    function automatic t_dir_row mk_row(input bit do_cfg, input int cfg_val,
                                        input logic [1:0] cmd, input int pos, input int val,
                                        input int l, input int r, input int tag,
                                        input bit typed, input logic want_status);
        t_dir_row row;
        row.do_cfg             = do_cfg;
        row.cfg_val            = cfg_val;
        row.item.command       = cmd;
        row.item.position      = pos[rdcw_pkg::FIELD_W-1:0];
        row.item.element_value = val[rdcw_pkg::FIELD_W-1:0];
        row.item.left_end      = l[rdcw_pkg::FIELD_W-1:0];
        row.item.right_end     = r[rdcw_pkg::FIELD_W-1:0];
        row.item.query_tag     = tag[rdcw_pkg::TAG_W-1:0];
        row.typed              = typed;
        row.want_status        = want_status;
        return row;
    endfunction

    task automatic send_request(input rdcw_pkg::t_in_item it, input bit typed,
                                input rdcw_pkg::t_out_item want);
        rdcw_pkg::t_out_item ans;
        while (!calm && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        step_window_model(it, ans);
        answers_due.push_back(typed ? want : ans);
        items_sent++;
    endtask

    task automatic write_length(input int v);
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        i_cfg_data  <= v[rdcw_pkg::COUNT_W-1:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        length_reg = v & 'h7FF;
    endtask

    function automatic int pick_length();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1;
            2:       return 2047;
            3, 4:    return 1024;
            5:       return int'($urandom_range(2047, 1025));
            default: return int'($urandom_range(1024, 1));
        endcase
    endfunction

    task automatic run_window_phase();
        rdcw_pkg::t_in_item it;
        int                 hi;
        int                 pool;
        int                 l;
        int                 r;
        int                 roll;
        int                 cap;
        hi = visible_limit();
        if (hi > 0 && $urandom_range(99) < 30) begin
            cap           = (hi - 1 > 1022) ? 1022 : hi - 1;
            r             = int'($urandom_range(cap));
            it            = rand_item(rdcw_pkg::CMD_QUERY);
            it.left_end   = to_field(r + 1);
            it.right_end  = to_field(r);
        end else begin
            it = rand_item(rdcw_pkg::CMD_CLEAR);
        end
        send_request(it, 1'b0, '0);
        pool = $urandom_range(1) ? 7 : VALUES - 1;
        repeat ($urandom_range(12, 1)) begin
            it = rand_item(rdcw_pkg::CMD_LOAD);
            if ($urandom_range(99) < 80 && written_prefix < DEPTH)
                it.position = to_field(written_prefix);
            it.element_value = to_field(int'($urandom_range(pool)));
            send_request(it, 1'b0, '0);
        end
        repeat ($urandom_range(15, 3)) begin
            it = rand_item(rdcw_pkg::CMD_QUERY);
            hi = visible_limit();
            if (hi == 0) begin
                it.left_end  = '1;
                it.right_end = to_field(int'($urandom_range(DEPTH - 3)));
            end else begin
                roll = int'($urandom_range(99));
                if (roll < 75) begin
                    r = win_r + int'($urandom_range(6)) - 3;
                    if (r < 0) r = 0;
                    if (r > hi - 1) r = hi - 1;
                    l = win_l + int'($urandom_range(6)) - 3;
                    if (l < 0) l = 0;
                    if (l > r + 1) l = r + 1;
                    if (l > DEPTH - 1) l = DEPTH - 1;
                end else if (roll < 90) begin
                    l = int'($urandom_range(hi - 1));
                    r = l - 1 + int'($urandom_range(32));
                    if (r > hi - 1) r = hi - 1;
                    if (r < 0) r = 0;
                end else if (roll < 95) begin
                    cap = (hi - 1 > 1022) ? 1022 : hi - 1;
                    r   = int'($urandom_range(cap));
                    l   = r + 1;
                end else begin
                    l = 0;
                    r = hi - 1;
                end
                it.left_end  = to_field(l);
                it.right_end = to_field(r);
            end
            send_request(it, 1'b0, '0);
        end
    endtask

    task automatic run_noise_phase();
        rdcw_pkg::t_in_item it;
        int                 roll;
        repeat ($urandom_range(10, 3)) begin
            roll = int'($urandom_range(99));
            if (roll < 25) begin
                it = rand_item(rdcw_pkg::CMD_LOAD);
            end else if (roll < 60) begin
                it = rand_item(rdcw_pkg::CMD_QUERY);
                if (!query_is_safe(int'(it.left_end), int'(it.right_end))) begin
                    it.left_end  = '1;
                    it.right_end = to_field(int'($urandom_range(DEPTH - 3)));
                end
            end else if (roll < 75) begin
                it = rand_item(rdcw_pkg::CMD_CLEAR);
            end else begin
                it = rand_item(CMD_UNKNOWN);
            end
            send_request(it, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                report_mismatch("answer with nothing pending, tag",
                                int'(o_out_item.answer_tag), -1);
            end else begin
                oldest = answers_due.pop_front();
                if (o_out_item.distinct_count !== oldest.distinct_count)
                    report_mismatch("distinct_count", int'(o_out_item.distinct_count),
                                    int'(oldest.distinct_count));
                if (o_out_item.answer_tag !== oldest.answer_tag)
                    report_mismatch("answer_tag", int'(o_out_item.answer_tag),
                                    int'(oldest.answer_tag));
                if (o_out_item.status !== oldest.status)
                    report_mismatch("status", int'(o_out_item.status), int'(oldest.status));
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 23);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("range_distinct_count_window_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        rdcw_pkg::t_out_item want;
        reset_window_model();

        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 1,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_LOAD, 1023, 1023, 1023, 1023, 'hFFFF, 1,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_LOAD, 1, 1023, 0, 0, 1, 1,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_LOAD, 2, 5, 0, 0, 2, 0,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_LOAD, 3, 5, 0, 0, 3, 0,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, CMD_UNKNOWN, 1023, 1023, 1023, 1023, 5, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 'h155, 'h2AA, 0, 3, 6, 0,
                                  rdcw_pkg::STATUS_OK));
        // load while the window holds elements
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_LOAD, 4, 9, 0, 0, 7, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 3, 1, 8, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 1023, 0, 9, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 2, 3, 10, 0,
                                  rdcw_pkg::STATUS_OK));
        // empty range, window becomes empty
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 4, 3, 11, 1,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 0, 0, 12, 0,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_CLEAR, 0, 0, 0, 0, 13, 1,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_LOAD, 4, 1023, 0, 0, 14, 1,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 0, 4, 15, 0,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_CLEAR, 0, 0, 0, 0, 16, 1,
                                  rdcw_pkg::STATUS_OK));
        // zero length refuses every query
        dir_rows.push_back(mk_row(1, 0, rdcw_pkg::CMD_QUERY, 0, 0, 0, 0, 17, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 1, 0, 18, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(1, 2, rdcw_pkg::CMD_QUERY, 0, 0, 0, 1, 19, 0,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 0, 2, 20, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 2, 1, 21, 1,
                                  rdcw_pkg::STATUS_OK));
        // length above the array depth saturates
        dir_rows.push_back(mk_row(1, 2047, rdcw_pkg::CMD_QUERY, 0, 0, 0, 4, 22, 0,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 1023, 1021, 23, 1,
                                  rdcw_pkg::STATUS_REFUSED));
        dir_rows.push_back(mk_row(1, 1, rdcw_pkg::CMD_QUERY, 0, 0, 0, 0, 24, 0,
                                  rdcw_pkg::STATUS_OK));
        dir_rows.push_back(mk_row(0, 0, rdcw_pkg::CMD_QUERY, 0, 0, 0, 1, 25, 1,
                                  rdcw_pkg::STATUS_REFUSED));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].do_cfg) write_length(dir_rows[k].cfg_val);
            want.distinct_count = '0;
            want.answer_tag     = dir_rows[k].item.query_tag;
            want.status         = dir_rows[k].want_status;
            send_request(dir_rows[k].item, dir_rows[k].typed, want);
        end

        while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
            calm = (items_sent >= 400 && items_sent < 560);
            if ($urandom_range(99) < 25) write_length(pick_length());
            if ($urandom_range(99) < 70)
                run_window_phase();
            else
                run_noise_phase();
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("range_distinct_count_window_unit_tb OK");
        end else begin
            $display("range_distinct_count_window_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
